>>> rtl/srt_pkg.sv
// Shared types and constants of the shortest-remaining-time scheduler.
package srt_pkg;

    localparam int JOBS   = 16;
    localparam int IDX_W  = (JOBS > 1) ? $clog2(JOBS) : 1;
    localparam int UNIT_W = 16;
    localparam int TIME_W = 32;
    localparam int JOB_W  = 4;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0]  CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0]  CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0]  CMD_CLEAR = 2'd2;
    localparam logic [TIME_W-1:0] TIME_MAX  = '1;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(JOBS - 1);
    localparam logic [7:0]        JOBS_LIM  = 8'(JOBS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [UNIT_W-1:0] burst;
        logic [UNIT_W-1:0] remaining;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic             clr;
        logic [IDX_W-1:0] addr;
        entry_t           entry;
    } wr_req_t;

endpackage

>>> rtl/srt_table.sv
// Job table: one synchronous memory of burst and remaining time, with per-entry valid bits.
module srt_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  srt_pkg::wr_req_t           wr,
    input  logic [srt_pkg::IDX_W-1:0]  rd_addr,
    output srt_pkg::entry_t            rd_entry
);

    srt_pkg::entry_t           mem [srt_pkg::JOBS];
    logic [srt_pkg::JOBS-1:0]  valid_reg;
    srt_pkg::entry_t           rd_data_reg;
    logic                      rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.clr)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // an entry never written since reset or clear reads as an empty job
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/shortest_remaining_time_scheduler_unit.sv
// Top level of the shortest-remaining-time scheduler: command handling, table scan and results.
//
//  channel  | signals                        | contents
//  ---------+--------------------------------+---------------------------------------------
//  s_axis   | s_tvalid s_tready s_tdata      | request: tuser cmd, tdata job + burst
//           | s_tuser                        |
//  m_axis   | m_tvalid m_tready m_tdata      | result: done_job, turnaround, waiting time
//
// A load or clear request is written as it is accepted. A tick is accepted in idle, then
// scan reads all JOBS entries of the single table read port for the shortest live job,
// last compares the last entry and update writes the chosen entry back.
// Reset clears valid bits, time and control at once; there is no clearing pass.
// A finished result waits in the output register; a tick that completes a job holds in
// its update step while that register is still full, and no request is taken meanwhile.
module shortest_remaining_time_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] job, [19:4] burst, [23:20] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [3:0] done_job, [35:4] turnaround_time,
                                   // [67:36] waiting_time, [71:68] zero
);

    srt_pkg::state_t                state_reg, state_next;
    logic [srt_pkg::IDX_W-1:0]      idx_reg;
    logic                           cmp_vld_reg;
    logic [srt_pkg::IDX_W-1:0]      cmp_idx_reg;
    logic                           found_reg;
    logic [srt_pkg::IDX_W-1:0]      best_idx_reg;
    srt_pkg::entry_t                best_reg;
    logic [srt_pkg::TIME_W-1:0]     time_reg;
    logic                           m_tvalid_reg;
    logic [srt_pkg::JOB_W-1:0]      done_job_reg;
    logic [srt_pkg::TIME_W-1:0]     turnaround_reg;
    logic [srt_pkg::TIME_W-1:0]     waiting_reg;

    srt_pkg::wr_req_t               wr;
    srt_pkg::entry_t                rd_entry;
    logic                           s_acc;
    logic [srt_pkg::CMD_W-1:0]      cmd;
    logic [srt_pkg::JOB_W-1:0]      job;
    logic [srt_pkg::UNIT_W-1:0]     burst;
    logic                           job_ok;
    logic                           better;
    logic [srt_pkg::UNIT_W-1:0]     new_rem;
    logic                           out_free;
    logic                           emit;
    logic [srt_pkg::TIME_W-1:0]     best_burst_w;

    assign s_acc   = s_tvalid && s_tready;
    assign cmd     = s_tuser;
    assign job     = s_tdata[3:0];
    assign burst   = s_tdata[19:4];
    assign job_ok  = ({4'b0000, job} < srt_pkg::JOBS_LIM);
    assign new_rem = best_reg.remaining - 16'd1;
    assign out_free = !m_tvalid_reg || m_tready;
    assign best_burst_w = {16'd0, best_reg.burst};

    // compare the entry that the previous scan cycle read
    assign better = cmp_vld_reg && (rd_entry.remaining != '0)
                    && (!found_reg || (rd_entry.remaining < best_reg.remaining));

    srt_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_addr  (idx_reg),
        .rd_entry (rd_entry)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srt_pkg::ST_IDLE:
            begin
                if (s_acc && (cmd == srt_pkg::CMD_TICK))
                begin
                    state_next = srt_pkg::ST_SCAN;
                end
            end
            srt_pkg::ST_SCAN:
            begin
                if (idx_reg == srt_pkg::LAST_IDX)
                begin
                    state_next = srt_pkg::ST_LAST;
                end
            end
            srt_pkg::ST_LAST:
            begin
                state_next = srt_pkg::ST_UPDATE;
            end
            srt_pkg::ST_UPDATE:
            begin
                if (!found_reg || (new_rem != '0) || out_free)
                begin
                    state_next = srt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srt_pkg::ST_IDLE;
            end
        endcase
    end

    // the table is only written outside the scan, so reads never meet a pending write
    always_comb
    begin
        s_tready = 1'b0;
        emit     = 1'b0;
        wr       = '0;
        unique case (state_reg)
            srt_pkg::ST_IDLE:
            begin
                s_tready             = 1'b1;
                wr.en                = s_acc && (cmd == srt_pkg::CMD_LOAD) && job_ok;
                wr.clr               = s_acc && (cmd == srt_pkg::CMD_CLEAR);
                wr.addr              = srt_pkg::IDX_W'(job);
                wr.entry.burst       = burst;
                wr.entry.remaining   = burst;
            end
            srt_pkg::ST_UPDATE:
            begin
                wr.en                = found_reg && ((new_rem != '0) || out_free);
                wr.addr              = best_idx_reg;
                wr.entry.burst       = best_reg.burst;
                wr.entry.remaining   = new_rem;
                emit                 = found_reg && (new_rem == '0) && out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= srt_pkg::ST_IDLE;
            idx_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            time_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == srt_pkg::ST_SCAN);
            if (state_reg == srt_pkg::ST_SCAN)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else
            begin
                idx_reg <= '0;
            end
            if (state_reg == srt_pkg::ST_IDLE)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
            if (s_acc && (cmd == srt_pkg::CMD_CLEAR))
            begin
                time_reg <= '0;
            end
            else if (s_acc && (cmd == srt_pkg::CMD_TICK) && (time_reg != srt_pkg::TIME_MAX))
            begin
                time_reg <= time_reg + 1'b1;
            end
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= idx_reg;
        if (better)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_reg     <= rd_entry;
        end
        if (emit)
        begin
            done_job_reg   <= srt_pkg::JOB_W'(best_idx_reg);
            turnaround_reg <= time_reg;
            waiting_reg    <= (time_reg >= best_burst_w) ? (time_reg - best_burst_w) : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, waiting_reg, turnaround_reg, done_job_reg};

    a_emit_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (state_reg == srt_pkg::ST_UPDATE) && found_reg)
        else $error("result raised outside the update step");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == srt_pkg::ST_SCAN) || (state_reg == srt_pkg::ST_LAST))
        |-> !wr.en && !wr.clr)
        else $error("table written during a scan");

    a_time_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        ((time_reg == srt_pkg::TIME_MAX) && !(s_acc && (cmd == srt_pkg::CMD_CLEAR)))
        |=> (time_reg == srt_pkg::TIME_MAX))
        else $error("time counter wrapped");

    a_wait_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (waiting_reg <= turnaround_reg))
        else $error("waiting time exceeds turnaround time");

endmodule
